### rtl/flr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants of the filtered line receiver.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int LINE_BYTES = 128;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int CNT_W      = 32;

  localparam int PREFIX_A_LEN = 19;
  localparam int PREFIX_B_LEN = 16;
  localparam int PA_IDX_W     = $clog2(PREFIX_A_LEN);
  localparam int PB_IDX_W     = $clog2(PREFIX_B_LEN);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // {"type":"discovery"
  localparam logic [7:0] PREFIX_A [PREFIX_A_LEN] = '{
    8'h7B, 8'h22, 8'h74, 8'h79, 8'h70, 8'h65, 8'h22, 8'h3A, 8'h22,
    8'h64, 8'h69, 8'h73, 8'h63, 8'h6F, 8'h76, 8'h65, 8'h72, 8'h79, 8'h22
  };
  // {"type":"bridge"
  localparam logic [7:0] PREFIX_B [PREFIX_B_LEN] = '{
    8'h7B, 8'h22, 8'h74, 8'h79, 8'h70, 8'h65, 8'h22, 8'h3A, 8'h22,
    8'h62, 8'h72, 8'h69, 8'h64, 8'h67, 8'h65, 8'h22
  };

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    HEALTH_SILENT  = 2'd0,
    HEALTH_PARTIAL = 2'd1,
    HEALTH_OK      = 2'd2
  } health_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic              ready;
    logic [ADDR_W-1:0] held;
    logic [CNT_W-1:0]  bytes;
    logic [CNT_W-1:0]  lines;
    logic [CNT_W-1:0]  drops;
  } status_t;

  typedef struct packed {
    logic latched;
    logic dropped;
    logic rd_hit;
  } flags_t;

endpackage

`default_nettype wire

### rtl/filtered_line_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filtered_line_receiver
// Builds newline-ended lines from received bytes, keeps wanted lines by prefix.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tuser opcode, s_tdata byte+index
//  m_*     | out | m_tvalid / m_tready  | m_tdata status, counters, read data
//
//  One beat per cycle while m_tready stays high: state and the result
//  register load together at the input handshake edge.
//  The state registers double as result fields, so a beat is taken whenever
//  the result register is empty or is being drained in the same cycle, outside reset.
//  Store reads go through the line buffer's registered read port.
//  rst is synchronous; counters, fill position and flags clear, the line
//  buffer contents do not (reads are bounded by the current line length).
//  A stall on m_tready holds the result and blocks s_tready.
// ----------------------------------------------------------------------------
module filtered_line_receiver (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] 0
  input  wire logic [1:0]   s_tuser,   // [1:0] opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata    // [0] line_ready, [1] latched_now,
                                       // [2] dropped_now, [9:3] line_length,
                                       // [17:10] read_data, [49:18] bytes_count,
                                       // [81:50] lines_count, [113:82] drops_count,
                                       // [115:114] link_health, [119:116] 0
);

  logic                        accept;
  flr_pkg::store_wr_t          wr;
  flr_pkg::flags_t             flags_c;
  flr_pkg::flags_t             flags;
  flr_pkg::status_t            st;
  logic [7:0]                  rd_q;
  logic [flr_pkg::ADDR_W-1:0]  line_length;
  logic [7:0]                  read_data;
  flr_pkg::health_t            health;

  // result register free, or emptied this cycle; nothing taken during reset
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  flr_assembler u_asm (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (s_tuser),
    .rx_byte    (s_tdata[7:0]),
    .read_index (s_tdata[14:8]),
    .wr         (wr),
    .flags      (flags_c),
    .status     (st)
  );

  flr_line_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (s_tdata[14:8]),
    .rd_data (rd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      flags    <= '0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
        flags    <= flags_c;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    line_length = st.ready ? st.held : '0;
    read_data   = flags.rd_hit ? rd_q : 8'h00;
    if (st.lines != '0) begin
      health = flr_pkg::HEALTH_OK;
    end else if (st.bytes != '0) begin
      health = flr_pkg::HEALTH_PARTIAL;
    end else begin
      health = flr_pkg::HEALTH_SILENT;
    end
  end

  assign m_tdata = {4'b0000, health, st.drops, st.lines, st.bytes, read_data,
                    line_length, flags.dropped, flags.latched, st.ready};

  // a line cannot both latch and drop on the same beat
  a_latch_xor_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(flags.latched && flags.dropped))
    else $error("latched_now and dropped_now both set");

  // a latch leaves the slot occupied
  a_latch_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && flags.latched) |-> st.ready)
    else $error("latched line not marked ready");

  // a held line always passed one of the prefixes
  a_held_len: assert property (@(posedge clk) disable iff (rst)
    st.ready |-> (st.held >= flr_pkg::ADDR_W'(flr_pkg::PREFIX_B_LEN)))
    else $error("held line shorter than shortest prefix");

  // every accepted byte beat advances the byte counter by one
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == flr_pkg::OP_BYTE) |=> (st.bytes == $past(st.bytes) + 1'b1))
    else $error("byte counter did not advance");

  // drops never outnumber counted lines' increments on one beat
  a_drop_with_line: assert property (@(posedge clk) disable iff (rst)
    (accept && flags_c.dropped) |=> (st.lines == $past(st.lines) + 1'b1))
    else $error("drop without line count");

endmodule

`default_nettype wire

### rtl/flr_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_line_store
// Line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flr_line_store (
  input  wire logic                      clk,
  input  wire flr_pkg::store_wr_t        wr,
  input  wire logic                      rd_en,
  input  wire logic [flr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  logic [7:0] mem [flr_pkg::LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/flr_assembler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_assembler
// Line fill, incremental prefix match, latch/release and counters.
// ----------------------------------------------------------------------------
module flr_assembler (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [1:0]                 opcode,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic [flr_pkg::ADDR_W-1:0] read_index,
  output flr_pkg::store_wr_t              wr,
  output flr_pkg::flags_t                 flags,
  output flr_pkg::status_t                status
);

  logic [flr_pkg::ADDR_W-1:0] fill;
  logic [flr_pkg::ADDR_W-1:0] fill_next;
  logic                       pa_match;
  logic                       pa_match_next;
  logic                       pb_match;
  logic                       pb_match_next;
  flr_pkg::status_t           st;
  flr_pkg::status_t           st_next;

  logic is_byte, is_rel, is_read;
  logic take, newline, chr, room, keep;
  logic [flr_pkg::ADDR_W-1:0] bound;

  always_comb begin
    is_byte = 1'b0;
    is_rel  = 1'b0;
    is_read = 1'b0;
    case (flr_pkg::opcode_t'(opcode))
      flr_pkg::OP_BYTE:    is_byte = 1'b1;
      flr_pkg::OP_RELEASE: is_rel  = 1'b1;
      flr_pkg::OP_READ:    is_read = 1'b1;
      default: ;
    endcase

    // CR is ignored; everything is ignored while a line is held
    take    = is_byte && !st.ready && (rx_byte != flr_pkg::CHAR_CR);
    newline = take && (rx_byte == flr_pkg::CHAR_LF);
    chr     = take && (rx_byte != flr_pkg::CHAR_LF);
    room    = fill != flr_pkg::ADDR_W'(flr_pkg::LINE_BYTES - 1);
    keep    = (fill != '0) &&
              ((pa_match && fill >= flr_pkg::ADDR_W'(flr_pkg::PREFIX_A_LEN)) ||
               (pb_match && fill >= flr_pkg::ADDR_W'(flr_pkg::PREFIX_B_LEN)));

    bound = st.ready ? st.held : fill;

    wr.en   = accept && chr && room;
    wr.addr = fill;
    wr.data = rx_byte;

    flags.latched = newline && keep;
    flags.dropped = newline && !keep;
    flags.rd_hit  = is_read && (read_index < bound);

    fill_next     = fill;
    pa_match_next = pa_match;
    pb_match_next = pb_match;
    st_next       = st;

    if (is_byte) begin
      st_next.bytes = st.bytes + 1'b1;
    end
    if (chr && room) begin
      fill_next = fill + 1'b1;
      if (fill < flr_pkg::ADDR_W'(flr_pkg::PREFIX_A_LEN) &&
          rx_byte != flr_pkg::PREFIX_A[fill[flr_pkg::PA_IDX_W-1:0]]) begin
        pa_match_next = 1'b0;
      end
      if (fill < flr_pkg::ADDR_W'(flr_pkg::PREFIX_B_LEN) &&
          rx_byte != flr_pkg::PREFIX_B[fill[flr_pkg::PB_IDX_W-1:0]]) begin
        pb_match_next = 1'b0;
      end
    end
    if (newline) begin
      st_next.lines = st.lines + 1'b1;
      fill_next     = '0;
      pa_match_next = 1'b1;
      pb_match_next = 1'b1;
      if (keep) begin
        st_next.ready = 1'b1;
        st_next.held  = fill;
      end else begin
        st_next.drops = st.drops + 1'b1;
      end
    end
    if (is_rel) begin
      st_next.ready = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      pa_match <= 1'b1;
      pb_match <= 1'b1;
      st       <= '0;
    end else if (accept) begin
      fill     <= fill_next;
      pa_match <= pa_match_next;
      pb_match <= pb_match_next;
      st       <= st_next;
    end
  end

  assign status = st;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the filtered line receiver: drives opcode beats with
// random gaps and back-pressure, predicts every status beat in a small
// scoreboard and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] OP_UNUSED   = 2'd3;  // no operation is defined for it
  localparam logic [7:0] CR_CHAR     = 8'h0D;
  localparam logic [7:0] LF_CHAR     = 8'h0A;
  localparam int         STORE_DEPTH = 128;
  localparam int         RAND_BEATS  = 750;

  typedef enum {
    LINE_DISCOVERY, LINE_BRIDGE, LINE_BENT, LINE_CUT, LINE_LONG, LINE_NOISE, LINE_EMPTY
  } line_kind_t;

  typedef struct packed {
    logic        line_ready;
    logic        latched_now;
    logic        dropped_now;
    logic [6:0]  line_length;
    logic [7:0]  read_data;
    logic [31:0] bytes_count;
    logic [31:0] lines_count;
    logic [31:0] drops_count;
    logic [1:0]  link_health;
  } line_status_t;

  // Tracks the receiver state beat by beat and holds the status beats due.
  class line_status_board;
    string        pfx_a = "{\"type\":\"discovery\"";
    string        pfx_b = "{\"type\":\"bridge\"";
    logic [7:0]   store [STORE_DEPTH];
    int unsigned  fill_len = 0;
    int unsigned  held_len = 0;
    bit           holding = 0;
    bit           a_ok = 1;
    bit           b_ok = 1;
    logic [31:0]  byte_total = 0;
    logic [31:0]  line_total = 0;
    logic [31:0]  drop_total = 0;
    line_status_t status_due [$];
    int           errors = 0;
    int           kept = 0;
    int           dropped = 0;
    int           reads = 0;
    int           releases = 0;

    function void take_input(logic [1:0] op, logic [7:0] b, logic [6:0] idx);
      line_status_t st;
      int unsigned  bound;
      st = '0;
      case (op)
        flr_pkg::OP_BYTE: begin
          byte_total++;
          // CR is dropped; everything is ignored while a line is held
          if (!holding && b != CR_CHAR) begin
            if (b != LF_CHAR) begin
              // one slot is kept free, overlong lines lose their tail
              if (fill_len + 1 < STORE_DEPTH) begin
                if (fill_len < pfx_a.len() && b != pfx_a[fill_len]) a_ok = 0;
                if (fill_len < pfx_b.len() && b != pfx_b[fill_len]) b_ok = 0;
                store[fill_len] = b;
                fill_len++;
              end
            end else begin
              line_total++;
              if (fill_len > 0 && ((a_ok && fill_len >= pfx_a.len()) ||
                                   (b_ok && fill_len >= pfx_b.len()))) begin
                holding = 1;
                held_len = fill_len;
                st.latched_now = 1'b1;
                kept++;
              end else begin
                drop_total++;
                st.dropped_now = 1'b1;
                dropped++;
              end
              fill_len = 0;
              a_ok = 1;
              b_ok = 1;
            end
          end
        end
        flr_pkg::OP_RELEASE: begin
          if (holding) releases++;
          holding = 0;
        end
        flr_pkg::OP_READ: begin
          reads++;
          bound = holding ? held_len : fill_len;
          if (idx < bound) st.read_data = store[idx];
        end
        default: ;
      endcase
      st.line_ready  = holding;
      st.line_length = holding ? held_len[6:0] : 7'd0;
      st.bytes_count = byte_total;
      st.lines_count = line_total;
      st.drops_count = drop_total;
      st.link_health = (line_total != 0) ? flr_pkg::HEALTH_OK :
                       (byte_total != 0) ? flr_pkg::HEALTH_PARTIAL : flr_pkg::HEALTH_SILENT;
      status_due.push_back(st);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [119:0] d);
      line_status_t want;
      if (status_due.size() == 0) begin
        $error("status beat with nothing outstanding");
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare("line_ready",  want.line_ready,  d[0]);
      compare("latched_now", want.latched_now, d[1]);
      compare("dropped_now", want.dropped_now, d[2]);
      compare("line_length", want.line_length, d[9:3]);
      compare("read_data",   want.read_data,   d[17:10]);
      compare("bytes_count", want.bytes_count, d[49:18]);
      compare("lines_count", want.lines_count, d[81:50]);
      compare("drops_count", want.drops_count, d[113:82]);
      compare("link_health", want.link_health, d[115:114]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;

  line_status_board sb = new();
  int               beats = 0;
  bit               calm = 0;   // no gaps on either side while set

  always #4 clk = ~clk;

  filtered_line_receiver DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Sink side: random stalls, none inside the calm window.
  always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 32);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_status(m_tdata);
  end

  // One input beat: optional gap, then hold until the handshake.
  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic [6:0] idx);
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, idx, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_input(op, b, idx);
    beats++;
    calm = (beats >= 300 && beats < 420);
    @(negedge clk);
  endtask

  // Stop sending until every status beat has come back.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.status_due.size() != 0);
  endtask

  task automatic send_line(line_kind_t kind);
    logic [7:0] text [$];
    string      pfx;
    int         n;
    int         spot;
    logic [7:0] c;
    pfx = $urandom_range(0, 1) ? sb.pfx_a : sb.pfx_b;
    if (kind == LINE_DISCOVERY) pfx = sb.pfx_a;
    if (kind == LINE_BRIDGE) pfx = sb.pfx_b;
    case (kind)
      LINE_CUT: begin
        n = $urandom_range(1, pfx.len() - 1);
        for (int i = 0; i < n; i++) text.push_back(pfx[i]);
      end
      LINE_NOISE: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          text.push_back(($urandom_range(0, 9) == 0) ? LF_CHAR : 8'($urandom_range(0, 255)));
      end
      LINE_EMPTY: ;
      default: for (int i = 0; i < pfx.len(); i++) text.push_back(pfx[i]);
    endcase
    if (kind == LINE_BENT) begin
      spot = $urandom_range(0, pfx.len() - 1);
      text[spot] = text[spot] ^ 8'($urandom_range(1, 255));
    end
    // payload after the prefix; long lines may run past the store size
    n = 0;
    if (kind inside {LINE_DISCOVERY, LINE_BRIDGE, LINE_BENT}) n = $urandom_range(0, 12);
    if (kind == LINE_LONG) n = $urandom_range(120, 150) - pfx.len();
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(32, 126));
      text.push_back(c);
    end
    if (kind != LINE_NOISE) text.push_back(LF_CHAR);
    foreach (text[i]) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(flr_pkg::OP_BYTE, CR_CHAR, 7'($urandom_range(0, 127)));
      // peek at the partial line now and then
      if ($urandom_range(0, 29) == 0)
        send_beat(flr_pkg::OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 31)));
      send_beat(flr_pkg::OP_BYTE, text[i], 7'($urandom_range(0, 127)));
    end
  endtask

  // Held line: read it back, push a few bytes that must be ignored, and usually free it.
  task automatic serve_held_line;
    int unsigned idx;
    logic [7:0]  c;
    repeat ($urandom_range(0, 4)) begin
      idx = $urandom_range(0, 1) ? $urandom_range(0, sb.held_len - 1) : $urandom_range(0, 127);
      send_beat(flr_pkg::OP_READ, 8'($urandom_range(0, 255)), 7'(idx));
    end
    repeat ($urandom_range(0, 3)) begin
      c = ($urandom_range(0, 9) < 3) ? LF_CHAR : 8'($urandom_range(0, 255));
      send_beat(flr_pkg::OP_BYTE, c, 7'($urandom_range(0, 127)));
    end
    // sometimes left held, so the next line is swallowed whole
    if ($urandom_range(0, 9) != 0)
      send_beat(flr_pkg::OP_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    if ($urandom_range(0, 9) == 0)
      send_beat(flr_pkg::OP_RELEASE, 8'h00, 7'd0);
  endtask

  initial begin
    line_kind_t kind;
    int         seq;
    int         pick;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle-state ops, CR only, empty line, edge byte values,
    // reads inside and past the partial line, unused opcode.
    send_beat(flr_pkg::OP_READ,    8'h00,   7'd0);
    send_beat(OP_UNUSED,           8'h00,   7'd0);
    send_beat(flr_pkg::OP_RELEASE, 8'h00,   7'd0);
    send_beat(flr_pkg::OP_BYTE,    CR_CHAR, 7'd0);
    send_beat(flr_pkg::OP_BYTE,    LF_CHAR, 7'd0);
    send_beat(flr_pkg::OP_BYTE,    8'hFF,   7'd127);
    send_beat(flr_pkg::OP_BYTE,    8'h00,   7'd0);
    send_beat(flr_pkg::OP_READ,    8'h00,   7'd0);
    send_beat(flr_pkg::OP_READ,    8'hFF,   7'd1);
    send_beat(flr_pkg::OP_READ,    8'h00,   7'd2);
    send_beat(flr_pkg::OP_READ,    8'h00,   7'd127);
    send_beat(flr_pkg::OP_BYTE,    8'h7F,   7'd0);
    send_beat(flr_pkg::OP_BYTE,    8'h80,   7'd0);
    send_beat(flr_pkg::OP_BYTE,    CR_CHAR, 7'd0);
    send_beat(flr_pkg::OP_BYTE,    LF_CHAR, 7'd0);
    send_beat(OP_UNUSED,           8'hFF,   7'd127);
    send_beat(flr_pkg::OP_RELEASE, 8'hFF,   7'd127);

    // Random: mostly prefixed lines, with bent, cut, overlong and noise lines.
    seq = 0;
    while (beats < RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 25) ? LINE_DISCOVERY :
             (pick < 45) ? LINE_BRIDGE :
             (pick < 60) ? LINE_BENT :
             (pick < 72) ? LINE_CUT :
             (pick < 74) ? LINE_LONG :
             (pick < 90) ? LINE_NOISE : LINE_EMPTY;
      if (seq == 4) kind = LINE_LONG;
      send_line(kind);
      if (sb.holding) serve_held_line();
      if (seq == 8) drain();
      seq++;
    end

    drain();
    repeat (16) @(posedge clk);
    $display("run covered %0d beats: %0d lines kept, %0d dropped, %0d reads, %0d releases",
             beats, sb.kept, sb.dropped, sb.reads, sb.releases);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog, far beyond any correct run.
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
